// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL of the BMP pixel decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/bmpl_pkg.sv =====
// Types, constants and the sRGB linearization table of the BMP pixel decoder.
`timescale 1ns / 1ps

package bmpl_pkg;

  localparam int unsigned MAX_DIM      = 4096;
  localparam int unsigned HEADER_BYTES = 54;

  localparam logic [7:0] SIG_FIRST  = 8'h42;  // 'B'
  localparam logic [7:0] SIG_SECOND = 8'h4D;  // 'M'

  localparam logic [5:0] POS_SIG_FIRST  = 6'd0;
  localparam logic [5:0] POS_SIG_SECOND = 6'd1;
  localparam logic [5:0] POS_WIDTH      = 6'd18;
  localparam logic [5:0] POS_HEIGHT     = 6'd22;
  localparam logic [5:0] POS_LAST       = 6'(HEADER_BYTES - 1);

  typedef enum logic [1:0] {
    KIND_PIXEL,
    KIND_HEADER,
    KIND_BAD_SIG,
    KIND_TOO_LARGE
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PIXELS,
    PH_PAD,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef struct packed {
    logic       start_of_file;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    kind_t       kind;
    logic [23:0] pixel_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] luminance;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic        last_pixel;
  } out_word_t;

  // Strobes from the parser that step the luminance accumulator.
  typedef struct packed {
    logic       load_blue;
    logic       add_green;
    logic [7:0] value;
  } luma_ctl_t;

  typedef logic [255:0][16:0] lin_table_t;

  // Linear light in Q1.16 for each sRGB byte, evaluated at elaboration.
  // The power 2.4 is found as t^2 * t^0.4, with t^0.4 taken by a bisection
  // on y^5 <= t^2 in Q30.
  function automatic lin_table_t build_lin_table();
    lin_table_t      tbl;
    longint unsigned t;
    longint unsigned t2;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned y2;
    longint unsigned y4;
    longint unsigned p;
    for (int c = 0; c < 256; c++) begin
      if (c <= 10) begin
        tbl[c] = 17'((longint'(c) * 6553600 + 164730) / 329460);
      end else begin
        t  = (longint'(40 * c + 561) << 30) / 10761;
        t2 = (t * t) >> 30;
        lo = 0;
        hi = 64'd1 << 30;
        for (int it = 0; it < 32; it++) begin
          if (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            y2  = (mid * mid) >> 30;
            y4  = (y2 * y2) >> 30;
            p   = (y4 * mid) >> 30;
            if (p <= t2) begin
              lo = mid;
            end else begin
              hi = mid - 1;
            end
          end
        end
        tbl[c] = 17'((t2 * lo + (64'd1 << 43)) >> 44);
      end
    end
    return tbl;
  endfunction

  localparam lin_table_t LIN_TABLE = build_lin_table();

endpackage

// ===== src/bmpl_stream_if.sv =====
// Valid/ready stream interface carrying one payload word per handshake.
`timescale 1ns / 1ps

interface bmpl_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/bmp24_pixel_decoder_luma_core.sv =====
// Top level of the 24-bit BMP decoder with per-pixel sRGB luminance.
//
//   channel   direction   word               handshake
//   bytes     in          start_of_file,     valid/ready
//                         data_byte
//   results   out         kind .. last_pixel valid/ready
//
// A byte enters the input register, is parsed from there once the output
// register can advance, and its result, if any, is registered in the output
// register. One byte per cycle is sustained while the output is not stalled;
// the parser step from input register to output register sets that figure.
// Synchronous reset returns the parser to idle, waiting for a start byte.
// A stalled output holds the input register; bytes keep flowing while the
// output register is empty or being taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bmp24_pixel_decoder_luma_core import bmpl_pkg::*; (
  input logic   clk,
  input logic   rst,
  bmpl_stream_if.sink   bytes,
  bmpl_stream_if.source results
);

  in_word_t    in_r;
  logic        in_r_valid;
  out_word_t   res;
  logic        res_valid;
  logic        advance;
  logic        fire;
  logic        parse_valid;
  out_word_t   parse_word;
  luma_ctl_t   luma_ctl;
  logic [15:0] luminance;

  assign advance     = !res_valid || results.ready;
  assign fire        = in_r_valid && advance;
  assign bytes.ready = !in_r_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_r_valid <= 1'b0;
    end else if (bytes.valid && bytes.ready) begin
      in_r_valid <= 1'b1;
    end else if (fire) begin
      in_r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      in_r <= bytes.payload;
    end
  end

  bmpl_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .word         (in_r),
    .luminance    (luminance),
    .luma_ctl     (luma_ctl),
    .result_valid (parse_valid),
    .result       (parse_word)
  );

  bmpl_luma u_luma (
    .clk       (clk),
    .ctl       (luma_ctl),
    .luminance (luminance)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= parse_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= parse_word;
    end
  end

  assign results.valid   = res_valid;
  assign results.payload = res;

  `ASSERT_RST(a_empty_output_takes_bytes, !res_valid |-> bytes.ready, "input stalled with empty output")
  `ASSERT_RST(a_parsed_result_lands, fire && parse_valid |=> res_valid, "parsed result was dropped")
  `ASSERT_RST(a_last_is_index_zero, res_valid && res.last_pixel |-> res.kind == KIND_PIXEL && res.pixel_index == '0, "last pixel flag with nonzero index")
  `ASSERT_RST(a_size_only_in_header, res_valid && res.kind != KIND_HEADER |-> res.image_width == '0 && res.image_height == '0, "dimensions outside header word")

endmodule

// ===== src/bmpl_luma.sv =====
// Luminance accumulator: linearizes each channel and sums Rec.709 weights.
`timescale 1ns / 1ps

module bmpl_luma import bmpl_pkg::*; (
  input  logic        clk,
  input  luma_ctl_t   ctl,
  output logic [15:0] luminance
);

  localparam logic [15:0] W_RED   = 16'd13933;
  localparam logic [15:0] W_GREEN = 16'd46871;
  localparam logic [15:0] W_BLUE  = 16'd4732;
  localparam logic [32:0] ROUND   = 33'd32768;

  logic [16:0] lin;
  logic [31:0] acc;
  logic [32:0] total;

  assign lin = LIN_TABLE[ctl.value];

  // Blue and green products are folded in as their bytes arrive, so the
  // red byte only adds one more product.
  always_ff @(posedge clk) begin
    if (ctl.load_blue) begin
      acc <= 32'(lin * W_BLUE);
    end else if (ctl.add_green) begin
      acc <= acc + 32'(lin * W_GREEN);
    end
  end

  assign total = {1'b0, acc} + 33'(lin * W_RED) + ROUND;

  assign luminance = total[32] ? 16'hFFFF : total[31:16];

endmodule

// ===== src/bmpl_parser.sv =====
// Header and pixel parser: phase control, counters and result formation.
`timescale 1ns / 1ps

module bmpl_parser import bmpl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  in_word_t    word,
  input  logic [15:0] luminance,
  output luma_ctl_t   luma_ctl,
  output logic        result_valid,
  output out_word_t   result
);

  phase_t      phase, phase_next;
  logic [5:0]  header_count, header_count_next;
  logic [31:0] width_word, width_word_next;
  logic [31:0] height_word, height_word_next;
  logic [12:0] column_count, column_count_next;
  logic [1:0]  byte_in_pixel, byte_in_pixel_next;
  logic [1:0]  pad_left, pad_left_next;
  logic [7:0]  held_blue, held_blue_next;
  logic [7:0]  held_green, held_green_next;
  logic [23:0] index_down, index_down_next;

  // A start-of-file byte is byte 0 of a fresh header whatever the phase.
  phase_t      cur_phase;
  logic [5:0]  cur_count;
  logic [31:0] cur_width;
  logic [31:0] cur_height;
  logic [31:0] got_width;
  logic [31:0] got_height;
  logic        bad_sig;
  logic        too_large;
  logic [25:0] area;
  logic [12:0] column_inc;
  logic [7:0]  b;

  assign b          = word.data_byte;
  assign cur_phase  = word.start_of_file ? PH_HEADER : phase;
  assign cur_count  = word.start_of_file ? 6'd0 : header_count;
  assign cur_width  = word.start_of_file ? 32'd0 : width_word;
  assign cur_height = word.start_of_file ? 32'd0 : height_word;

  assign bad_sig = (cur_count == POS_SIG_FIRST && b != SIG_FIRST) ||
                   (cur_count == POS_SIG_SECOND && b != SIG_SECOND);

  always_comb begin
    got_width  = cur_width;
    got_height = cur_height;
    if (cur_count >= POS_WIDTH && cur_count < POS_HEIGHT) begin
      got_width = cur_width | (32'(b) << {cur_count[1:0] - POS_WIDTH[1:0], 3'b000});
    end else if (cur_count >= POS_HEIGHT && cur_count < POS_HEIGHT + 6'd4) begin
      got_height = cur_height | (32'(b) << {cur_count[1:0] - POS_HEIGHT[1:0], 3'b000});
    end
  end

  assign too_large  = (got_width > 32'(MAX_DIM)) || (got_height > 32'(MAX_DIM));
  assign area       = got_width[12:0] * got_height[12:0];
  assign column_inc = column_count + 13'd1;

  // Next state.
  always_comb begin
    phase_next         = phase;
    header_count_next  = header_count;
    width_word_next    = width_word;
    height_word_next   = height_word;
    column_count_next  = column_count;
    byte_in_pixel_next = byte_in_pixel;
    pad_left_next      = pad_left;
    held_blue_next     = held_blue;
    held_green_next    = held_green;
    index_down_next    = index_down;
    if (fire) begin
      unique case (cur_phase)
        PH_HEADER: begin
          phase_next        = PH_HEADER;
          header_count_next = cur_count;
          width_word_next   = got_width;
          height_word_next  = got_height;
          if (bad_sig) begin
            phase_next = PH_ERROR;
          end else if (cur_count != POS_LAST) begin
            header_count_next = cur_count + 6'd1;
          end else if (too_large) begin
            phase_next = PH_ERROR;
          end else begin
            column_count_next  = '0;
            byte_in_pixel_next = '0;
            pad_left_next      = '0;
            if (got_width == '0 || got_height == '0) begin
              phase_next = PH_DONE;
            end else begin
              phase_next      = PH_PIXELS;
              index_down_next = 24'(area - 26'd1);
            end
          end
        end
        PH_PAD: begin
          pad_left_next = pad_left - 2'd1;
          if (pad_left == 2'd1) begin
            phase_next = PH_PIXELS;
          end
        end
        PH_PIXELS: begin
          unique case (byte_in_pixel)
            2'd0: begin
              held_blue_next     = b;
              byte_in_pixel_next = 2'd1;
            end
            2'd1: begin
              held_green_next    = b;
              byte_in_pixel_next = 2'd2;
            end
            default: begin
              byte_in_pixel_next = 2'd0;
              if (index_down == '0) begin
                phase_next = PH_DONE;
              end else begin
                index_down_next   = index_down - 24'd1;
                column_count_next = column_inc;
                if (column_inc >= width_word[12:0]) begin
                  column_count_next = '0;
                  if (width_word[1:0] != 2'd0) begin
                    pad_left_next = width_word[1:0];
                    phase_next    = PH_PAD;
                  end
                end
              end
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // Outputs.
  always_comb begin
    result_valid       = 1'b0;
    result             = '0;
    result.kind        = KIND_PIXEL;
    luma_ctl.value     = b;
    luma_ctl.load_blue = fire && cur_phase == PH_PIXELS && byte_in_pixel == 2'd0;
    luma_ctl.add_green = fire && cur_phase == PH_PIXELS && byte_in_pixel == 2'd1;
    unique case (cur_phase)
      PH_HEADER: begin
        if (bad_sig) begin
          result_valid = fire;
          result.kind  = KIND_BAD_SIG;
        end else if (cur_count == POS_LAST) begin
          result_valid = fire;
          if (too_large) begin
            result.kind = KIND_TOO_LARGE;
          end else begin
            result.kind         = KIND_HEADER;
            result.image_width  = got_width[12:0];
            result.image_height = got_height[12:0];
          end
        end
      end
      PH_PIXELS: begin
        if (byte_in_pixel == 2'd2) begin
          result_valid       = fire;
          result.kind        = KIND_PIXEL;
          result.pixel_index = index_down;
          result.red         = b;
          result.green       = held_green;
          result.blue        = held_blue;
          result.luminance   = luminance;
          result.last_pixel  = (index_down == '0);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      header_count  <= '0;
      column_count  <= '0;
      byte_in_pixel <= '0;
      pad_left      <= '0;
      width_word    <= '0;
      height_word   <= '0;
    end else begin
      phase         <= phase_next;
      header_count  <= header_count_next;
      column_count  <= column_count_next;
      byte_in_pixel <= byte_in_pixel_next;
      pad_left      <= pad_left_next;
      width_word    <= width_word_next;
      height_word   <= height_word_next;
    end
  end

  always_ff @(posedge clk) begin
    held_blue  <= held_blue_next;
    held_green <= held_green_next;
    index_down <= index_down_next;
  end

endmodule
